// ----- hdl/rgb_kernel_convolution_filter_defines.svh -----
// Assertion macros shared by the checker.
`ifndef RGB_KERNEL_CONVOLUTION_FILTER_DEFINES_SVH
`define RGB_KERNEL_CONVOLUTION_FILTER_DEFINES_SVH
// Implication checked on every clock while out of reset.
`define RKC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rkc check failed");
// Next-cycle implication checked while out of reset.
`define RKC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rkc check failed");
`endif

// ----- hdl/rkc_pkg.sv -----
`timescale 1ns / 1ps
package rkc_pkg;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxKernelDef = 5;

  typedef enum logic [2:0] {
    MODE_BLUR    = 3'd0,
    MODE_BOX     = 3'd1,
    MODE_PREWITT = 3'd2,
    MODE_ROBERTS = 3'd3,
    MODE_SOBEL   = 3'd4,
    MODE_KIRSCH  = 3'd5,
    MODE_MDIF    = 3'd6,
    MODE_NONE    = 3'd7
  } mode_t;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef logic [7:0] pix_t;
  // One window column: index 0 is the oldest row, 4 the newest pixel.
  typedef pix_t col5_t [5];

  // Word handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  cc;
    logic [11:0] cr;
    logic        fdone;
    logic [5*8-1:0] r_col;
    logic [5*8-1:0] g_col;
    logic [5*8-1:0] b_col;
  } fe_word_t;

  // Combined 3x3 kernel weight (pair 0 plus pair 1 share one division only
  // when applied separately, so both are kept).
  function automatic logic signed [3:0] k3w(input logic [2:0] m, input logic p,
                                            input int dy, input int dx);
    logic signed [3:0] w;
    w = 4'sd0;
    case (m)
      MODE_BLUR: if (!p) w = (dy == 1 && dx == 1) ? 4'sd4 :
                       ((dy == 1 || dx == 1) ? 4'sd2 : 4'sd1);
      MODE_BOX: if (!p) w = 4'sd1;
      MODE_PREWITT: begin
        if (!p) w = (dx == 0) ? -4'sd1 : ((dx == 2) ? 4'sd1 : 4'sd0);
        else    w = (dy == 0) ? -4'sd1 : ((dy == 2) ? 4'sd1 : 4'sd0);
      end
      MODE_ROBERTS: begin
        if (!p) w = (dy == 1 && dx == 2) ? 4'sd1 : ((dy == 2 && dx == 1) ? -4'sd1 : 4'sd0);
        else    w = (dy == 1 && dx == 1) ? -4'sd1 : ((dy == 2 && dx == 2) ? 4'sd1 : 4'sd0);
      end
      MODE_SOBEL: begin
        if (!p) w = (dx == 1) ? 4'sd0 : (((dx == 0) ? -4'sd1 : 4'sd1) *
                    ((dy == 1) ? 4'sd2 : 4'sd1));
        else    w = (dy == 1) ? 4'sd0 : (((dy == 0) ? -4'sd1 : 4'sd1) *
                    ((dx == 1) ? 4'sd2 : 4'sd1));
      end
      MODE_KIRSCH: begin
        if (!p) w = (dx == 2) ? 4'sd5 : ((dy == 1 && dx == 1) ? 4'sd0 : -4'sd3);
        else    w = (dy == 2) ? 4'sd5 : ((dy == 1 && dx == 1) ? 4'sd0 : -4'sd3);
      end
      default: w = 4'sd0;
    endcase
    return w;
  endfunction

  function automatic logic signed [2:0] k5w(input logic p, input int dy, input int dx);
    logic signed [2:0] w;
    logic signed [2:0] a;
    a = 3'sd0;
    if (!p) begin
      case (dy)
        0, 4:    a = (dx == 1 || dx == 3) ? 3'sd1 : 3'sd0;
        2:       a = (dx == 2) ? 3'sd0 : ((dx == 1 || dx == 3) ? 3'sd3 : 3'sd1);
        default: a = (dx == 2) ? 3'sd0 : ((dx == 1 || dx == 3) ? 3'sd2 : 3'sd1);
      endcase
      // The left half of the vertical kernel is negative.
      w = (dx < 2) ? -a : a;
    end else begin
      case (dy)
        0, 4:    a = (dx == 0 || dx == 4) ? 3'sd0 : 3'sd1;
        2:       a = 3'sd0;
        default: a = (dx == 2) ? 3'sd3 : ((dx == 1 || dx == 3) ? 3'sd2 : 3'sd1);
      endcase
      // The upper half of the horizontal kernel is negative.
      w = (dy < 2) ? -a : a;
    end
    return w;
  endfunction
endpackage

// ----- hdl/rkc_front.sv -----
`timescale 1ns / 1ps
module rkc_front import rkc_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [2:0]  mode,
  input  logic [10:0] width,
  input  logic [11:0] height,
  input  logic        q_full,
  output logic        full,
  output logic        wr_en,
  output fe_word_t    wr_word,
  output logic        emit
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  logic [4*24-1:0] mem [MAX_WIDTH];
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [CW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [CW-1:0] c;
  logic [11:0]   r;
  logic [4*24-1:0] rd_r, fwd_r;
  logic [4*24-1:0] old_lines;
  logic [4*24-1:0] new_lines;
  logic [AW-1:0] addr, addr_r;
  logic          v_r, hit_r, leave;
  logic [23:0]   px_r;
  logic [2:0]    md_r;
  logic [9:0]    cc_r, cc_now;
  logic [11:0]   cr_r, cr_now;
  logic          fd_r, fd_now;
  logic          em_r, em_now;

  always_comb begin
    if (width == 11'd0) w_eff = CW'(1);
    else if ({1'b0, width} > 12'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width);
    h_eff = (height == 12'd0) ? 12'd1 : height;
    c = (col_r >= w_eff) ? '0 : col_r;
    r = (row_r >= h_eff) ? '0 : row_r;
    addr = c[AW-1:0];
  end

  // The held word moves into the queue whenever the queue has room.
  assign leave = v_r && !q_full;
  assign full  = v_r && q_full;
  assign wr_en = v_r;
  assign emit  = em_r;

  // The line store is read at the accepting edge and written back when the
  // word leaves. With a one-pixel row the same column is read while it is
  // being written, so the written lines are passed on directly.
  always_ff @(posedge clk) begin
    if (leave) mem[addr_r] <= new_lines;
    if (acc) rd_r <= mem[addr];
  end

  always_comb begin
    old_lines = hit_r ? fwd_r : rd_r;
    new_lines = {old_lines[3*24-1:0], px_r};
  end

  always_comb begin
    col_nxt = c + CW'(1);
    row_nxt = r;
    if (col_nxt >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r + 12'd1 >= h_eff) ? 12'd0 : r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    if (mode <= MODE_KIRSCH) em_now = (r >= 12'd2) && (c >= CW'(2));
    else if (mode == MODE_MDIF) em_now = (r >= 12'd4) && (c >= CW'(4));
    else em_now = 1'b0;
    cc_now = (mode == MODE_MDIF) ? 10'(c - CW'(2)) : 10'(c - CW'(1));
    cr_now = (mode == MODE_MDIF) ? r - 12'd2 : r - 12'd1;
    fd_now = (r == h_eff - 12'd1) && (c == w_eff - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hit_r  <= leave && (addr_r == addr);
      fwd_r  <= new_lines;
      addr_r <= addr;
      px_r   <= {blue_in, green_in, red_in};
      md_r   <= mode;
      cc_r   <= cc_now;
      cr_r   <= cr_now;
      fd_r   <= fd_now;
      em_r   <= em_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (acc) begin
      v_r <= 1'b1;
    end else if (leave) begin
      v_r <= 1'b0;
    end
  end

  always_comb begin
    wr_word.mode  = md_r;
    wr_word.cc    = cc_r;
    wr_word.cr    = cr_r;
    wr_word.fdone = fd_r;
    for (int k = 0; k < 4; k++) begin
      wr_word.r_col[8*(4-k)+:8] = old_lines[24*(3-k)+0 +:8];
      wr_word.g_col[8*(4-k)+:8] = old_lines[24*(3-k)+8 +:8];
      wr_word.b_col[8*(4-k)+:8] = old_lines[24*(3-k)+16+:8];
    end
    wr_word.r_col[7:0] = px_r[7:0];
    wr_word.g_col[7:0] = px_r[15:8];
    wr_word.b_col[7:0] = px_r[23:16];
  end
endmodule

// ----- hdl/rkc_queue.sv -----
`timescale 1ns / 1ps
module rkc_queue import rkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fe_word_t din,
  input  logic     din_emit,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output fe_word_t dout,
  output logic     dout_emit
);
  localparam int Depth = 4;
  fe_word_t    q_r [Depth];
  logic        e_r [Depth];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  assign full  = (cnt_r == 3'(Depth));
  assign empty = (cnt_r == 3'd0);
  assign dout  = q_r[rp_r];
  assign dout_emit = e_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wp_r] <= din;
      e_r[wp_r] <= din_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push && !full) - 3'(pop && !empty);
    end
  end
endmodule

// ----- hdl/rkc_back.sv -----
`timescale 1ns / 1ps
module rkc_back import rkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  fe_word_t    q_word,
  input  logic        q_emit,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        pop,
  output logic [9:0]  centre_col,
  output logic [11:0] centre_row,
  output logic signed [9:0] red_out,
  output logic signed [9:0] green_out,
  output logic signed [9:0] blue_out,
  output logic        frame_done
);
  // Stage 1 shifts the window; stage 2 holds the two partial sums per
  // channel; the division and addition are combinational and feed the output register.
  pix_t win_r [3][5][5];
  logic        v1_r, v2_r, vo_r;
  logic [2:0]  m1_r, m2_r;
  logic [9:0]  cc1_r, cc2_r;
  logic [11:0] cr1_r, cr2_r;
  logic        fd1_r, fd2_r;
  logic signed [12:0] s0_r [3];
  logic signed [12:0] s1_r [3];
  logic signed [9:0]  res [3];
  logic [9:0]  cco_r;
  logic [11:0] cro_r;
  logic        fdo_r;
  logic signed [9:0] ro_r [3];
  logic adv;

  // Every queue word shifts the window, so words pop whenever the pipe moves and the queue is not empty.
  assign adv   = !vo_r || pop;
  assign q_pop = adv && !q_empty;
  assign out_empty = !vo_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int dy = 0; dy < 5; dy++) begin
        for (int dx = 0; dx < 4; dx++) begin
          for (int ch = 0; ch < 3; ch++) win_r[ch][dy][dx] <= win_r[ch][dy][dx+1];
        end
        win_r[0][dy][4] <= q_word.r_col[8*(4-dy)+:8];
        win_r[1][dy][4] <= q_word.g_col[8*(4-dy)+:8];
        win_r[2][dy][4] <= q_word.b_col[8*(4-dy)+:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= q_word.mode;
      cc1_r <= q_word.cc;
      cr1_r <= q_word.cr;
      fd1_r <= q_word.fdone;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [12:0] a0;
        logic signed [12:0] a1;
        a0 = '0;
        a1 = '0;
        if (m1_r == MODE_MDIF) begin
          for (int dy = 0; dy < 5; dy++) begin
            for (int dx = 0; dx < 5; dx++) begin
              a0 = a0 + 13'(k5w(1'b0, dy, dx)) * $signed({5'd0, win_r[ch][dy][dx]});
              a1 = a1 + 13'(k5w(1'b1, dy, dx)) * $signed({5'd0, win_r[ch][dy][dx]});
            end
          end
        end else begin
          for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
              a0 = a0 + 13'(k3w(m1_r, 1'b0, dy, dx)) *
                   $signed({5'd0, win_r[ch][2+dy][2+dx]});
              a1 = a1 + 13'(k3w(m1_r, 1'b1, dy, dx)) *
                   $signed({5'd0, win_r[ch][2+dy][2+dx]});
            end
          end
        end
        s0_r[ch] <= a0;
        s1_r[ch] <= a1;
      end
      m2_r <= m1_r;
      cc2_r <= cc1_r;
      cr2_r <= cr1_r;
      fd2_r <= fd1_r;
    end
  end

  // Truncating division by a small constant on a magnitude, sign restored.
  function automatic logic signed [12:0] tdiv(input logic signed [12:0] v,
                                              input logic [2:0] m);
    logic [12:0] a;
    logic [12:0] q;
    logic [26:0] p;
    a = v[12] ? 13'(-v) : 13'(v);
    case (m)
      MODE_BLUR, MODE_PREWITT: q = a >> 4;
      MODE_BOX:     begin p = 27'(a) * 27'd7282;  q = 13'(p >> 16); end
      MODE_ROBERTS: q = a;
      MODE_SOBEL:   q = a >> 2;
      MODE_KIRSCH:  begin p = 27'(a) * 27'd4370;  q = 13'(p >> 16); end
      MODE_MDIF:    begin p = 27'(a) * 27'd5462;  q = 13'(p >> 16); end
      default:      q = a;
    endcase
    return v[12] ? -$signed(q) : $signed(q);
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [13:0] t;
      t = 14'(tdiv(s0_r[ch], m2_r)) + 14'(tdiv(s1_r[ch], m2_r));
      if (t > 14'sd511) res[ch] = 10'sd511;
      else if (t < -14'sd512) res[ch] = -10'sd512;
      else res[ch] = 10'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cco_r <= cc2_r;
      cro_r <= cr2_r;
      fdo_r <= fd2_r;
      for (int ch = 0; ch < 3; ch++) ro_r[ch] <= res[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop && q_emit;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
  end

  assign centre_col = cco_r;
  assign centre_row = cro_r;
  assign frame_done = fdo_r;
  assign red_out    = ro_r[0];
  assign green_out  = ro_r[1];
  assign blue_out   = ro_r[2];
endmodule

// ----- hdl/rgb_kernel_convolution_filter.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake         | Payload
// input    | in_push, in_full  | in_red_in, in_green_in, in_blue_in
// result   | out_empty,out_pop | centre, rgb out, frame_done
// config   | APB psel/penable  | filter_mode, image_width, image_height
// One pixel is accepted per clock while in_full is low; the line store has one read and one write per cycle.
// A pixel passes the front stage, the queue and the window, partial-sum and output registers before its result appears.
// Result stalls fill the four-word queue; in_full rises once it is full and the
// front stage also holds a word.
// Reset is synchronous; the line store is not cleared and holds rows once written.
module rgb_kernel_convolution_filter import rkc_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [9:0]  out_centre_col,
  output logic [11:0] out_centre_row,
  output logic signed [9:0] out_red_out,
  output logic signed [9:0] out_green_out,
  output logic signed [9:0] out_blue_out,
  output logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  mode_r;
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic        acc, wr_en, emit, q_empty, q_emit, q_pop, q_full;
  fe_word_t    wr_word, q_word;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BLUR;
      width_r  <= 11'd1024;
      height_r <= 12'd768;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_MODE:   mode_r   <= pwdata[2:0];
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_HEIGHT: height_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MODE:   prdata = {29'd0, mode_r};
      REG_WIDTH:  prdata = {21'd0, width_r};
      REG_HEIGHT: prdata = {20'd0, height_r};
      default:    prdata = '0;
    endcase
  end

  assign acc = in_push && !in_full;

  rkc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .acc,
    .red_in(in_red_in), .green_in(in_green_in), .blue_in(in_blue_in),
    .mode(mode_r), .width(width_r), .height(height_r),
    .q_full, .full(in_full),
    .wr_en, .wr_word, .emit
  );

  rkc_queue u_queue (
    .clk, .rst_n, .push(wr_en), .din(wr_word), .din_emit(emit), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_word), .dout_emit(q_emit)
  );

  rkc_back u_back (
    .clk, .rst_n, .q_empty, .q_word, .q_emit, .q_pop,
    .out_empty, .pop(out_pop),
    .centre_col(out_centre_col), .centre_row(out_centre_row),
    .red_out(out_red_out), .green_out(out_green_out), .blue_out(out_blue_out),
    .frame_done(out_frame_done)
  );
endmodule

// ----- hdl/rkc_checker.sv -----
`timescale 1ns / 1ps
`include "rgb_kernel_convolution_filter_defines.svh"
module rkc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [9:0] out_centre_col
);
  `RKC_ASSERT_NXT(a_res_hold, clk, rst_n, !out_empty && !out_pop, !out_empty)
  `RKC_ASSERT_NXT(a_col_hold, clk, rst_n, !out_empty && !out_pop, $stable(out_centre_col))
  `RKC_ASSERT_IMP(a_col_min, clk, rst_n, !out_empty, out_centre_col >= 10'd1)
  // The input only backs up behind a result that is waiting to be taken.
  `RKC_ASSERT_IMP(a_full_busy, clk, rst_n, in_full, !out_empty)
endmodule

bind rgb_kernel_convolution_filter rkc_checker u_rkc_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_centre_col
);
